### design/ostt_pkg.sv
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types and constants for the one-shot tick timer.
// ----------------------------------------------------------------------------
package ostt_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned DIV_STEPS  = DATA_W;
	localparam int unsigned MUL_STEPS  = PERIOD_W;
	localparam int unsigned STEP_W     = $clog2(DIV_STEPS);
	localparam int unsigned PADDR_W    = 3;

	// register index as seen on paddr[2]
	localparam logic REG_TICK_PERIOD = 1'b0;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_HALTED  = 2'd2,
		MODE_EXPIRED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_START    = 3'd1,
		OP_RESET    = 3'd2,
		OP_HALT     = 3'd3,
		OP_RESTART  = 3'd4,
		OP_STOP     = 3'd5,
		OP_CONTINUE = 3'd6
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_MULGO = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic                start_div;
		logic                start_mul;
		logic [DATA_W-1:0]   dividend;
		logic [PERIOD_W-1:0] divisor;
		logic [DATA_W-1:0]   multiplicand;
		logic [PERIOD_W-1:0] multiplier;
	} unit_cmd_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] product;
	} unit_sts_t;

endpackage

### design/ostt_arith.sv
// ----------------------------------------------------------------------------
// ostt_arith
// Shared serial unit: restoring divide (one quotient bit per cycle) and
// shift-add multiply (one multiplier bit per cycle) on a single adder.
// ----------------------------------------------------------------------------
module ostt_arith (
	input  logic               clk,
	input  logic               arst_n,
	input  ostt_pkg::unit_cmd_t cmd,
	output ostt_pkg::unit_sts_t sts
);
	import ostt_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic                is_div_q;
	logic [STEP_W-1:0]   step_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsor_q;
	logic [DATA_W-1:0]   dvd_q;
	logic [DATA_W-1:0]   acc_q;
	logic [DATA_W-1:0]   mcand_q;
	logic [PERIOD_W-1:0] mplier_q;

	logic [PERIOD_W:0]   rem_sh;
	logic [DATA_W-1:0]   add_a;
	logic [DATA_W-1:0]   add_b;
	logic                add_cin;
	logic [DATA_W:0]     sum;
	logic [STEP_W-1:0]   last_step;

	assign rem_sh = {rem_q, dvd_q[DATA_W-1]};

	// divide: rem_sh - divisor, carry out means no borrow
	always_comb begin
		if (is_div_q) begin
			add_a   = {{(DATA_W-PERIOD_W-1){1'b0}}, rem_sh};
			add_b   = ~{{(DATA_W-PERIOD_W){1'b0}}, dsor_q};
			add_cin = 1'b1;
		end else begin
			add_a   = acc_q;
			add_b   = mplier_q[0] ? mcand_q : '0;
			add_cin = 1'b0;
		end
	end

	assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};

	assign last_step = is_div_q ? STEP_W'(DIV_STEPS - 1) : STEP_W'(MUL_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			is_div_q <= 1'b0;
			step_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start_div || cmd.start_mul) begin
				busy_q   <= 1'b1;
				is_div_q <= cmd.start_div;
				step_q   <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q  <= '0;
			dvd_q  <= cmd.dividend;
			dsor_q <= cmd.divisor;
		end else if (cmd.start_mul) begin
			acc_q    <= '0;
			mcand_q  <= cmd.multiplicand;
			mplier_q <= cmd.multiplier;
		end else if (busy_q) begin
			if (is_div_q) begin
				if (sum[DATA_W]) begin
					rem_q <= sum[PERIOD_W-1:0];
				end else begin
					rem_q <= rem_sh[PERIOD_W-1:0];
				end
				dvd_q <= {dvd_q[DATA_W-2:0], sum[DATA_W]};
			end else begin
				acc_q    <= sum[DATA_W-1:0];
				mcand_q  <= {mcand_q[DATA_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[PERIOD_W-1:1]};
			end
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = dvd_q;
	assign sts.product  = acc_q;

endmodule

### design/ostt_ctrl.sv
// ----------------------------------------------------------------------------
// ostt_ctrl
// Mode rules, sequencer for the shared unit and the result register.
// ----------------------------------------------------------------------------
module ostt_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [2:0]                    op,
	input  logic [ostt_pkg::DATA_W-1:0]   duration,
	input  logic [ostt_pkg::PERIOD_W-1:0] tick_period,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          accepted,
	output logic [1:0]                    mode,
	output logic [ostt_pkg::DATA_W-1:0]   elapsed_ms,
	output ostt_pkg::unit_cmd_t           ucmd,
	input  ostt_pkg::unit_sts_t           usts
);
	import ostt_pkg::*;

	state_t            state_q;
	mode_t             mode_q;
	logic [DATA_W-1:0] count_q;
	logic [DATA_W-1:0] target_q;
	logic              ok_q;
	logic              rsp_valid_q;
	logic              rsp_ok_q;
	mode_t             rsp_mode_q;
	logic [DATA_W-1:0] rsp_elapsed_q;

	mode_t             mode_nxt;
	logic [DATA_W-1:0] cnt_nxt;
	logic [DATA_W-1:0] cnt_inc;
	logic              ok_nxt;
	logic              go_div;
	logic              cmd_take;
	logic              rsp_free;

	assign cnt_inc   = count_q + DATA_W'(1);
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd_valid && cmd_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		mode_nxt = mode_q;
		cnt_nxt  = count_q;
		ok_nxt   = 1'b0;
		go_div   = 1'b0;
		case (op_t'(op))
			OP_TICK: begin
				if (mode_q == MODE_RUNNING) begin
					cnt_nxt = cnt_inc;
					ok_nxt  = 1'b1;
					if (cnt_inc == target_q) begin
						mode_nxt = MODE_EXPIRED;
					end
				end
			end
			OP_START: begin
				if (mode_q == MODE_STOPPED) begin
					if (duration == '0) begin
						mode_nxt = MODE_EXPIRED;
						ok_nxt   = 1'b1;
					end else if (tick_period != '0) begin
						// outcome decided by the quotient: zero means too short
						go_div = 1'b1;
					end
				end
			end
			OP_RESET: begin
				if (mode_q inside {MODE_STOPPED, MODE_EXPIRED}) begin
					cnt_nxt  = '0;
					mode_nxt = MODE_STOPPED;
					ok_nxt   = 1'b1;
				end
			end
			OP_HALT: begin
				if (mode_q == MODE_RUNNING) begin
					mode_nxt = MODE_HALTED;
					ok_nxt   = 1'b1;
				end
			end
			OP_RESTART: begin
				if (mode_q != MODE_STOPPED) begin
					cnt_nxt  = '0;
					mode_nxt = MODE_RUNNING;
					ok_nxt   = 1'b1;
				end
			end
			OP_STOP: begin
				if (mode_q != MODE_EXPIRED) begin
					cnt_nxt  = '0;
					mode_nxt = MODE_STOPPED;
					ok_nxt   = 1'b1;
				end
			end
			OP_CONTINUE: begin
				if (mode_q == MODE_HALTED) begin
					mode_nxt = MODE_RUNNING;
					ok_nxt   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ucmd.start_div    = cmd_take && go_div;
	assign ucmd.start_mul    = (state_q == ST_MULGO);
	assign ucmd.dividend     = duration;
	assign ucmd.divisor      = tick_period;
	assign ucmd.multiplicand = count_q;
	assign ucmd.multiplier   = tick_period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_STOPPED;
			count_q     <= '0;
			target_q    <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						mode_q  <= mode_nxt;
						count_q <= cnt_nxt;
						ok_q    <= ok_nxt;
						state_q <= go_div ? ST_DIV : ST_MULGO;
					end
				end
				ST_DIV: begin
					if (usts.done) begin
						if (usts.quotient != '0) begin
							target_q <= usts.quotient;
							mode_q   <= MODE_RUNNING;
							ok_q     <= 1'b1;
						end
						state_q <= ST_MULGO;
					end
				end
				ST_MULGO: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (usts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_ok_q      <= ok_q;
			rsp_mode_q    <= mode_q;
			rsp_elapsed_q <= usts.product;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign accepted   = rsp_ok_q;
	assign mode       = rsp_mode_q;
	assign elapsed_ms = rsp_elapsed_q;

endmodule

### design/one_shot_tick_timer_unit.sv
// ----------------------------------------------------------------------------
// one_shot_tick_timer_unit
// Command-driven one-shot timer with a serial divider/multiplier.
// ----------------------------------------------------------------------------
//  port group   direction  handshake              payload
//  cmd          in         cmd_valid / cmd_ready  op, duration
//  rsp          out        rsp_valid / rsp_ready  accepted, mode, elapsed_ms
//  apb          in/out     psel / penable         paddr, pwdata in; prdata out
//
//  A start in stopped mode with nonzero duration and period runs a 32-step
//  divide, then a 16-step multiply for elapsed time. Every other command
//  runs the 16-step multiply only. Both use the single adder in ostt_arith.
//  cmd_ready is high only while idle; a result not yet taken holds the
//  finished item until rsp is free. Reset clears mode, count and target and
//  sets the period to 1.
// ----------------------------------------------------------------------------
module one_shot_tick_timer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [2:0]                   op,
	input  logic [31:0]                  duration,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         accepted,
	output logic [1:0]                   mode,
	output logic [31:0]                  elapsed_ms,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ostt_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ostt_pkg::*;

	logic [PERIOD_W-1:0] tick_period_q;
	logic                reg_hit;
	unit_cmd_t           ucmd;
	unit_sts_t           usts;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_TICK_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= PERIOD_W'(1);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			tick_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(32-PERIOD_W){1'b0}}, tick_period_q} : '0;

	ostt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.op         (op),
		.duration   (duration),
		.tick_period(tick_period_q),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.accepted   (accepted),
		.mode       (mode),
		.elapsed_ms (elapsed_ms),
		.ucmd       (ucmd),
		.usts       (usts)
	);

	ostt_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ucmd),
		.sts   (usts)
	);

endmodule

### design/ostt_checker.sv
// ----------------------------------------------------------------------------
// ostt_checker
// Port-level checks on the timer, bound to the top level.
// ----------------------------------------------------------------------------
module ostt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        accepted,
	input logic [1:0]  mode,
	input logic [31:0] elapsed_ms
);
	import ostt_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(accepted) && $stable(mode)
			&& $stable(elapsed_ms))
		else $error("result changed while stalled");

	// one request at a time: the unit is busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken while busy");

	// only reset and stop land in stopped mode, and both clear the count
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && accepted && mode == MODE_STOPPED |-> elapsed_ms == '0)
		else $error("stopped with nonzero elapsed time");

	// no result appears in the cycle right after a request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !rsp_valid |=> !rsp_valid)
		else $error("result too early");

endmodule

bind one_shot_tick_timer_unit ostt_checker u_ostt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_ready (cmd_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.accepted  (accepted),
	.mode      (mode),
	.elapsed_ms(elapsed_ms)
);
